// File: design/ttui_pkg.sv
// ----------------------------------------------------------------------------
// ttui_pkg: shared types for the text-to-unsigned-integer parser
// Holds the field widths and the classified-character word that travels
// from the front classifier through the queue to the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ttui_pkg;

    localparam int CH_W    = 8;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 64;
    localparam int CONS_W  = 16;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // One character after classification.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;     // 0..35, or 36 for a non-digit
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
    } cls_t;

endpackage

`default_nettype wire

// File: design/ttui_front.sv
// ----------------------------------------------------------------------------
// ttui_front: character classifier
// Decodes one input byte into digit value and class flags for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttui_front (
    input  wire logic [ttui_pkg::CH_W-1:0] ch,
    output ttui_pkg::cls_t                 cls
);

    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [7:0] CH_UX      = 8'h58;
    localparam logic [7:0] CH_LX      = 8'h78;
    localparam logic [7:0] UPPER_OFFS = 8'd55;   // 'A' - 10
    localparam logic [7:0] LOWER_OFFS = 8'd87;   // 'a' - 10
    localparam logic [ttui_pkg::DIGIT_W-1:0] DIGIT_NONE = 6'd36;

    logic [7:0] diff;

    always_comb begin
        diff = 8'd0;
        cls.digit = DIGIT_NONE;
        if (ch >= CH_0 && ch <= CH_9) begin
            diff = ch - CH_0;
            cls.digit = diff[ttui_pkg::DIGIT_W-1:0];
        end else if (ch >= CH_LA && ch <= CH_LZ) begin
            diff = ch - LOWER_OFFS;
            cls.digit = diff[ttui_pkg::DIGIT_W-1:0];
        end else if (ch >= CH_UA && ch <= CH_UZ) begin
            diff = ch - UPPER_OFFS;
            cls.digit = diff[ttui_pkg::DIGIT_W-1:0];
        end
        cls.is_space = (ch == CH_SP) || (ch >= CH_TAB && ch <= CH_CR);
        cls.is_plus  = (ch == CH_PLUS);
        cls.is_minus = (ch == CH_MINUS);
        cls.is_zero  = (ch == CH_0);
        cls.is_x     = (ch == CH_LX) || (ch == CH_UX);
    end

endmodule

`default_nettype wire

// File: design/ttui_queue.sv
// ----------------------------------------------------------------------------
// ttui_queue: two-entry word queue
// Decouples the classifier from the parse engine; push and pop may share
// a cycle, so a full-rate stream passes with no bubbles.
// ----------------------------------------------------------------------------
`default_nettype none

module ttui_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire ttui_pkg::cls_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output ttui_pkg::cls_t      pop_data
);

    ttui_pkg::cls_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg,   fill_next;
    logic       push, pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/ttui_back.sv
// ----------------------------------------------------------------------------
// ttui_back: parse engine
// Runs the whitespace / sign / prefix / digit sequence, one word per cycle
// unless a held result stalls it, with a single multiply-add on the accumulator and a registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttui_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [ttui_pkg::RADIX_W-1:0]   radix,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire ttui_pkg::cls_t                 pop_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ttui_pkg::VALUE_W-1:0]        m_value,
    output logic                                m_any_digits,
    output logic [ttui_pkg::CONS_W-1:0]         m_consumed
);

    localparam int RW    = ttui_pkg::RADIX_W;
    localparam int VW    = ttui_pkg::VALUE_W;
    localparam int CW    = ttui_pkg::CONS_W;
    localparam int SAT_W = (COUNT_WIDTH > CW) ? COUNT_WIDTH : CW;
    localparam logic [RW-1:0] BASE_AUTO = 6'd0;
    localparam logic [RW-1:0] BASE_OCT  = 6'd8;
    localparam logic [RW-1:0] BASE_DEC  = 6'd10;
    localparam logic [RW-1:0] BASE_HEX  = 6'd16;
    localparam logic [RW-1:0] BASE_MIN  = 6'd2;
    localparam logic [RW-1:0] BASE_MAX  = 6'd36;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_AFTERX,
        PH_DIGITS
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic                   neg_reg,    neg_next;
    logic [VW-1:0]          accum_reg,  accum_next;
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic                   seen_reg,   seen_next;
    logic [RW-1:0]          base_reg,   base_next;

    logic                   m_valid_reg,   m_valid_next;
    logic [VW-1:0]          m_value_reg,   m_value_next;
    logic                   m_any_reg,     m_any_next;
    logic [CW-1:0]          m_cons_reg,    m_cons_next;

    logic                   fire;
    logic                   pre_go, dig_go, fin;
    logic [RW-1:0]          pre_base, dig_base;
    logic [1:0]             cnt_inc;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [VW+RW-1:0]       prod;
    logic [SAT_W-1:0]       cnt_wide;
    logic [CW-1:0]          cons_sat;

    assign pop_ready    = !m_valid_reg || m_ready;
    assign fire         = pop_valid && pop_ready;
    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_any_digits = m_any_reg;
    assign m_consumed   = m_cons_reg;

    always_comb begin
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        accum_next   = accum_reg;
        seen_next    = seen_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_any_next   = m_any_reg;
        m_cons_next  = m_cons_reg;
        pre_go       = 1'b0;
        pre_base     = base_reg;
        dig_go       = 1'b0;
        dig_base     = base_reg;
        fin          = 1'b0;
        cnt_inc      = 2'd0;

        prod     = accum_reg * dig_base;
        cnt_wide = SAT_W'(count_reg);
        cons_sat = (cnt_wide > SAT_W'({CW{1'b1}})) ? {CW{1'b1}} : cnt_wide[CW-1:0];

        if (fire) begin
            unique case (phase_reg)
                PH_SPACE: begin
                    if (pop_data.is_space) begin
                        cnt_inc = 2'd1;
                    end else if (pop_data.is_plus || pop_data.is_minus) begin
                        neg_next   = pop_data.is_minus;
                        cnt_inc    = 2'd1;
                        base_next  = radix;
                        phase_next = PH_PREFIX;
                    end else begin
                        pre_go   = 1'b1;
                        pre_base = radix;
                    end
                end
                PH_PREFIX: begin
                    pre_go = 1'b1;
                end
                PH_ZERO: begin
                    if (pop_data.is_x) begin
                        base_next  = (base_reg == BASE_AUTO) ? BASE_HEX : base_reg;
                        phase_next = PH_AFTERX;
                    end else begin
                        dig_go   = 1'b1;
                        dig_base = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    end
                end
                PH_AFTERX: begin
                    if (pop_data.digit < BASE_HEX) begin
                        accum_next = VW'(pop_data.digit);
                        cnt_inc    = 2'd2;
                        phase_next = PH_DIGITS;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    dig_go = 1'b1;
                end
                default: begin
                    dig_go = 1'b1;
                end
            endcase

            // Prefix step: a leading zero may open a hex prefix or, in auto mode, octal.
            if (pre_go) begin
                if ((pre_base == BASE_AUTO || pre_base == BASE_HEX) && pop_data.is_zero) begin
                    seen_next  = 1'b1;
                    cnt_inc    = 2'd1;
                    base_next  = pre_base;
                    phase_next = PH_ZERO;
                end else begin
                    dig_go   = 1'b1;
                    dig_base = (pre_base == BASE_AUTO) ? BASE_DEC : pre_base;
                end
            end

            // Digit step: accumulate or end the number.
            if (dig_go) begin
                phase_next = PH_DIGITS;
                base_next  = dig_base;
                if (dig_base >= BASE_MIN && dig_base <= BASE_MAX
                        && pop_data.digit < dig_base) begin
                    prod       = accum_reg * dig_base;
                    accum_next = prod[VW-1:0] + VW'(pop_data.digit);
                    seen_next  = 1'b1;
                    cnt_inc    = 2'd1;
                end else begin
                    fin = 1'b1;
                end
            end
        end

        cnt_sum    = {1'b0, count_reg} + (COUNT_WIDTH+1)'(cnt_inc);
        count_next = cnt_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : cnt_sum[COUNT_WIDTH-1:0];

        if (fin) begin
            m_valid_next = 1'b1;
            m_value_next = neg_reg ? (VW'(0) - accum_reg) : accum_reg;
            m_any_next   = seen_reg;
            m_cons_next  = seen_reg ? cons_sat : {CW{1'b0}};
            phase_next   = PH_SPACE;
            neg_next     = 1'b0;
            accum_next   = {VW{1'b0}};
            count_next   = {COUNT_WIDTH{1'b0}};
            seen_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SPACE;
            neg_reg     <= 1'b0;
            accum_reg   <= {VW{1'b0}};
            count_reg   <= {COUNT_WIDTH{1'b0}};
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            accum_reg   <= accum_next;
            count_reg   <= count_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
        base_reg    <= base_next;
        m_value_reg <= m_value_next;
        m_any_reg   <= m_any_next;
        m_cons_reg  <= m_cons_next;
    end

endmodule

`default_nettype wire

// File: design/text_to_unsigned_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_unsigned_integer_parser: streaming text-to-integer parser
//
// Feed one character word per cycle on s_ch (s_valid/s_ready). Leading
// whitespace is skipped, one '+' or '-' is taken, then digits in the base
// held in the radix register (0 = detect from a 0x or 0 prefix). The first
// character that is not part of the number ends it and produces one result
// word on m_value / m_any_digits / m_consumed (m_valid/m_ready); that stop
// character is used up and the next string starts right after it.
// Write the radix on cfg_data with cfg_valid (cfg_ready is always high)
// while no string is in flight; it is latched at each string's first
// non-whitespace character.
// Throughput: one character per cycle unless the result receiver stalls, with the
// multiply-add on the 64-bit accumulator in the parse engine done combinationally.
// Result path: the stop character is written into the queue, the engine pops
// it and forms the result combinationally, and the result word is loaded
// into the output register.
// Reset: radix returns to 10, the queue empties, parsing restarts in the
// whitespace phase and no result is pending.
// Receiver stall: the result word holds, the engine stops draining the
// queue, and s_ready drops once the queue holds two words.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_unsigned_integer_parser #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Radix register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ttui_pkg::RADIX_W-1:0]  cfg_data,
    // Character input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ttui_pkg::CH_W-1:0]     s_ch,
    // Result output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ttui_pkg::VALUE_W-1:0]       m_value,
    output logic                               m_any_digits,
    output logic [ttui_pkg::CONS_W-1:0]        m_consumed
);

    logic [ttui_pkg::RADIX_W-1:0] radix_reg;
    ttui_pkg::cls_t               front_cls;
    ttui_pkg::cls_t               q_data;
    logic                         q_valid;
    logic                         q_ready;

    // Config: always ready; hold the radix until the next write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= ttui_pkg::RADIX_RESET;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    // Front: classify the byte on its way into the queue.
    ttui_front u_front (
        .ch  (s_ch),
        .cls (front_cls)
    );

    // Queue: lets the engine stall on the receiver without a bubble upstream.
    ttui_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // Back: parse state and registered result.
    ttui_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .radix        (radix_reg),
        .pop_valid    (q_valid),
        .pop_ready    (q_ready),
        .pop_data     (q_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_any_digits (m_any_digits),
        .m_consumed   (m_consumed)
    );

endmodule

`default_nettype wire

// File: design/ttui_checker.sv
// ----------------------------------------------------------------------------
// ttui_checker: port-level checks for the parser
// Watches the result channel for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module ttui_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [ttui_pkg::VALUE_W-1:0]  m_value,
    input wire logic                          m_any_digits,
    input wire logic [ttui_pkg::CONS_W-1:0]   m_consumed
);

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // No digits means value 0 and nothing consumed.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_any_digits |-> m_value == '0 && m_consumed == '0)
        else $error("empty number carries value or count");

    // Any digit counts at least one character.
    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_any_digits |-> m_consumed != '0)
        else $error("digits seen but nothing consumed");

endmodule

bind text_to_unsigned_integer_parser ttui_checker u_ttui_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_value      (m_value),
    .m_any_digits (m_any_digits),
    .m_consumed   (m_consumed)
);

`default_nettype wire
